>>> rtl/core/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Depends on nothing; the controller, datapath and top level use it.
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int DEN_BITS  = WORD_BITS - 1;
    localparam int WIDE_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_CMP = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    typedef struct packed {
        logic [2:0]                  mode;
        logic signed [WORD_BITS-1:0] a_num;
        logic [DEN_BITS-1:0]         a_den;
        logic signed [WORD_BITS-1:0] b_num;
        logic [DEN_BITS-1:0]         b_den;
    } req_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] res_num;
        logic [DEN_BITS-1:0]         res_den;
        logic                        is_equal;
        logic [1:0]                  error;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture request operands
        logic mul_a;     // first product pair
        logic mul_b;     // common denominator product
        logic form;      // form raw numerator and denominator magnitudes
        logic gcd_init;  // copy magnitudes into gcd registers
        logic gcd_step;  // advance the Euclid remainder step
        logic div_init;  // start reduction divisions
        logic div_step;  // one restoring division bit
        logic finish;    // build the response
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic early;     // result is decided without reduction
        logic gcd_done;  // divisor of the Euclid step is zero
        logic div_done;  // reduction divisions finished
    } sts_t;

endpackage

>>> rtl/core/rational_arith_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide and compare of
// two fractions, reduced by a gcd found with Euclid's algorithm.
// Early results (compare, errors, zero result, unused modes) skip the gcd and
// reduction; otherwise the Euclid steps (up to about 90) and the two reduction
// divisions all run on the single bit-serial 64-bit remainder unit. One request
// at a time; the next is taken in the cycle after the response. Reset (synchronous) idles.
module rational_arith_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rau_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rau_pkg::rsp_t m_data
);
    import rau_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller sequences products, the gcd loop and the reductions.
    rau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the operands, the shared remainder unit and the
    // registered response, which stays stable while m_valid waits.
    rau_dp u_dp (
        .aclk (aclk),
        .req  (s_data),
        .cmd  (cmd),
        .sts  (sts),
        .rsp  (m_data)
    );

endmodule

>>> rtl/core/rau_ctrl.sv
// Sequencing state machine for the rational arithmetic unit.
// Depends on rau_pkg; drives the command struct into rau_dp.
module rau_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rau_pkg::sts_t sts,
    output rau_pkg::cmd_t cmd
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_FORM, ST_GCD_INIT, ST_GCD,
        ST_DIV_INIT, ST_DIV, ST_FINISH, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_FORM;
            end
            ST_FORM: begin
                cmd.form   = 1'b1;
                state_next = ST_GCD_INIT;
            end
            ST_GCD_INIT: begin
                if (sts.early) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.gcd_init = 1'b1;
                    state_next   = ST_GCD;
                end
            end
            ST_GCD: begin
                if (sts.gcd_done) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_ready_out_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid both high");
    a_out_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid) else $error("finish did not present a response");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("response dropped");

endmodule

>>> rtl/core/rau_dp.sv
// Datapath of the rational arithmetic unit: products, Euclid gcd and
// bit-serial reduction divisions. Depends on rau_pkg; controlled by rau_ctrl.
module rau_dp (
    input  logic          aclk,
    input  rau_pkg::req_t req,
    input  rau_pkg::cmd_t cmd,
    output rau_pkg::sts_t sts,
    output rau_pkg::rsp_t rsp
);
    import rau_pkg::*;

    req_t                   req_reg;
    logic signed [WIDE_BITS-1:0] p1_reg, p2_reg;
    logic [WIDE_BITS-1:0]   nm_reg, dm_reg;
    logic                   neg_reg, early_reg;
    logic [1:0]             eerr_reg;
    logic                   eeq_reg;
    // Euclid: x, y and a serial remainder of x mod y.
    logic [WIDE_BITS-1:0]   gx_reg, gy_reg, rem_reg, quo_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   busy_reg;
    // Reduction: divide nm then dm by g.
    logic [WIDE_BITS-1:0]   g_reg, qn_reg;
    logic                   phase_reg, ddone_reg;
    rsp_t                   rsp_reg;

    logic [WIDE_BITS:0]     trial;
    logic [WIDE_BITS-1:0]   shifted;
    logic [WIDE_BITS-1:0]   lim;
    logic [WIDE_BITS-1:0]   nlim;
    logic signed [WIDE_BITS-1:0] rawn, rawd;
    logic                   a_zero, b_zero, d_zero;

    assign lim     = {{(WIDE_BITS-DEN_BITS){1'b0}}, {DEN_BITS{1'b1}}};
    assign nlim    = lim + {{(WIDE_BITS-1){1'b0}}, neg_reg};
    assign shifted = {rem_reg[WIDE_BITS-2:0], quo_reg[WIDE_BITS-1]};
    assign trial   = {1'b0, shifted} - {1'b0, (busy_reg ? gy_reg : g_reg)};
    assign a_zero  = (req_reg.a_den == '0);
    assign b_zero  = (req_reg.b_den == '0);
    assign d_zero  = (req_reg.b_num == '0);

    always_comb begin
        rawn = '0;
        rawd = '0;
        case (req_reg.mode)
            MODE_ADD: begin rawn = p1_reg + p2_reg; rawd = dm_reg; end
            MODE_SUB: begin rawn = p1_reg - p2_reg; rawd = dm_reg; end
            default:  begin rawn = p1_reg;          rawd = p2_reg; end
        endcase
    end

    assign sts.early    = early_reg;
    assign sts.gcd_done = !busy_reg && (gy_reg == '0);
    assign sts.div_done = ddone_reg;
    assign rsp          = rsp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= req;
        // Each product is one 32x32 multiply; two of them run side by side.
        if (cmd.mul_a) begin
            unique case (req_reg.mode)
                MODE_MUL: begin
                    p1_reg <= WIDE_BITS'(req_reg.a_num * req_reg.b_num);
                    p2_reg <= WIDE_BITS'($signed({1'b0, req_reg.a_den})
                              * $signed({1'b0, req_reg.b_den}));
                end
                MODE_DIV: begin
                    p1_reg <= WIDE_BITS'(req_reg.a_num
                              * $signed({1'b0, req_reg.b_den}));
                    p2_reg <= WIDE_BITS'($signed({1'b0, req_reg.a_den})
                              * req_reg.b_num);
                end
                default: begin
                    p1_reg <= WIDE_BITS'(req_reg.a_num
                              * $signed({1'b0, req_reg.b_den}));
                    p2_reg <= WIDE_BITS'(req_reg.b_num
                              * $signed({1'b0, req_reg.a_den}));
                end
            endcase
        end
        if (cmd.mul_b) begin
            // Common denominator for add and subtract.
            dm_reg <= WIDE_BITS'({1'b0, req_reg.a_den} * {1'b0, req_reg.b_den});
        end
        if (cmd.form) begin
            early_reg <= 1'b1;
            eerr_reg  <= ERR_NONE;
            eeq_reg   <= 1'b0;
            nm_reg    <= rawn[WIDE_BITS-1] ? WIDE_BITS'(-rawn) : rawn;
            dm_reg    <= rawd[WIDE_BITS-1] ? WIDE_BITS'(-rawd) : rawd;
            neg_reg   <= (rawn[WIDE_BITS-1] != rawd[WIDE_BITS-1]);
            if (req_reg.mode > MODE_CMP) begin
                eerr_reg <= ERR_NONE;
            end else if (a_zero || b_zero) begin
                eerr_reg <= ERR_DIV_ZERO;
            end else if (req_reg.mode == MODE_CMP) begin
                eeq_reg <= (p1_reg == p2_reg);
            end else if (req_reg.mode == MODE_DIV && d_zero) begin
                eerr_reg <= ERR_DIV_ZERO;
            end else if (rawn == '0) begin
                eerr_reg <= ERR_NONE;
            end else begin
                early_reg <= 1'b0;
            end
        end
        if (cmd.gcd_init) begin
            gx_reg   <= nm_reg;
            gy_reg   <= dm_reg;
            busy_reg <= 1'b0;
        end
        if (cmd.gcd_step) begin
            if (!busy_reg) begin
                // Start x mod y, one quotient bit a cycle.
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= gx_reg;
                cnt_reg  <= CNT_BITS'(WIDE_BITS);
            end else if (cnt_reg != '0) begin
                rem_reg <= trial[WIDE_BITS] ? shifted : trial[WIDE_BITS-1:0];
                quo_reg <= {quo_reg[WIDE_BITS-2:0], !trial[WIDE_BITS]};
                cnt_reg <= cnt_reg - 1'b1;
            end else begin
                busy_reg <= 1'b0;
                gx_reg   <= gy_reg;
                gy_reg   <= rem_reg;
            end
        end
        if (cmd.div_init) begin
            g_reg     <= gx_reg;
            rem_reg   <= '0;
            quo_reg   <= nm_reg;
            cnt_reg   <= CNT_BITS'(WIDE_BITS);
            phase_reg <= 1'b0;
            ddone_reg <= 1'b0;
        end
        if (cmd.div_step) begin
            if (cnt_reg != '0) begin
                rem_reg <= trial[WIDE_BITS] ? shifted : trial[WIDE_BITS-1:0];
                quo_reg <= {quo_reg[WIDE_BITS-2:0], !trial[WIDE_BITS]};
                cnt_reg <= cnt_reg - 1'b1;
            end else if (!phase_reg) begin
                qn_reg    <= quo_reg;
                phase_reg <= 1'b1;
                rem_reg   <= '0;
                quo_reg   <= dm_reg;
                cnt_reg   <= CNT_BITS'(WIDE_BITS);
            end else begin
                ddone_reg <= 1'b1;
            end
        end
        if (cmd.finish) begin
            rsp_reg.res_num  <= '0;
            rsp_reg.res_den  <= DEN_BITS'(1);
            rsp_reg.is_equal <= 1'b0;
            rsp_reg.error    <= ERR_NONE;
            if (early_reg) begin
                rsp_reg.is_equal <= eeq_reg;
                rsp_reg.error    <= eerr_reg;
            end else if (quo_reg > lim || qn_reg > nlim) begin
                rsp_reg.error <= ERR_OVERFLOW;
            end else begin
                rsp_reg.res_num <= neg_reg ? WORD_BITS'(-qn_reg)
                                           : qn_reg[WORD_BITS-1:0];
                rsp_reg.res_den <= quo_reg[DEN_BITS-1:0];
            end
        end
    end

    a_gcd_nonzero: assert property (@(posedge aclk)
        cmd.div_init |-> (gx_reg != '0)) else $error("zero gcd");
    a_step_excl: assert property (@(posedge aclk)
        !(cmd.gcd_step && cmd.div_step)) else $error("shared divider conflict");
    a_init_excl: assert property (@(posedge aclk)
        !(cmd.gcd_init && cmd.div_init)) else $error("init conflict");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the rational arithmetic unit.
// Depends on rau_pkg and rational_arith_unit; drives requests and checks results.
module testbench;
    import rau_pkg::*;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_data;
    logic  m_valid;
    logic  m_ready;
    rsp_t  m_data;

    // Results predicted for accepted requests, oldest first.
    rsp_t  expected_results[$];
    int    mismatches;
    int    results_seen;
    int    requests_sent;
    bit    hold_off;

    rational_arith_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Overall time limit, sized for the worst case of around 90 Euclid steps per
    // request plus idle gaps and stalls.
    initial begin
        #(8 * 30000000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Computes the reduced fraction that one request produces.
    function automatic rsp_t reduce_fraction(req_t rq);
        rsp_t        rs;
        longint      an;
        longint      ad;
        longint      bn;
        longint      bd;
        longint      num;
        longint      den;
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] g;
        logic [63:0] lim;
        bit          neg;
        rs.res_num  = '0;
        rs.res_den  = 31'd1;
        rs.is_equal = 1'b0;
        rs.error    = ERR_NONE;
        an  = longint'(rq.a_num);
        ad  = longint'({1'b0, rq.a_den});
        bn  = longint'(rq.b_num);
        bd  = longint'({1'b0, rq.b_den});
        num = 0;
        den = 1;
        lim = (64'd1 << (WORD_BITS - 1)) - 1;
        if (rq.mode > MODE_CMP) return rs;
        if (ad == 0 || bd == 0) begin
            rs.error = ERR_DIV_ZERO;
            return rs;
        end
        case (mode_t'(rq.mode))
            MODE_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            MODE_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            MODE_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            MODE_DIV: begin
                if (bn == 0) begin
                    rs.error = ERR_DIV_ZERO;
                    return rs;
                end
                num = an * bd;
                den = ad * bn;
            end
            default: begin
                rs.is_equal = (an * bd == bn * ad);
                return rs;
            end
        endcase
        nm  = (num < 0) ? 64'(-num) : 64'(num);
        dm  = (den < 0) ? 64'(-den) : 64'(den);
        neg = ((num < 0) != (den < 0)) && nm != 0;
        if (nm == 0) return rs;
        g  = euclid(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (dm > lim || nm > lim + (neg ? 1 : 0)) begin
            rs.error = ERR_OVERFLOW;
        end else begin
            rs.res_num = neg ? 32'(-nm) : 32'(nm);
            rs.res_den = 31'(dm);
        end
        return rs;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what,
            got, want);
    endtask

    // Sends one request, holding valid until it is taken; returns at the
    // following falling edge with valid still high.
    task automatic send_request(req_t rq);
        s_data  <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(reduce_fraction(rq));
        requests_sent++;
        @(negedge aclk);
    endtask

    // Idle gap after a request; valid drops only when the gap is not empty.
    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    function automatic logic [31:0] rand_num();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(1, 12));
            1: return 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
            2: return 31'($urandom_range(1, 1000));
            3: return ($urandom_range(0, 30) == 0) ? 31'd0 : 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    // Result side: check each response against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            rsp_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.res_num !== want.res_num)
                    report_mismatch("res_num", 64'(m_data.res_num), 64'(want.res_num));
                if (m_data.res_den !== want.res_den)
                    report_mismatch("res_den", 64'(m_data.res_den), 64'(want.res_den));
                if (m_data.is_equal !== want.is_equal)
                    report_mismatch("is_equal", 64'(m_data.is_equal),
                        64'(want.is_equal));
                if (m_data.error !== want.error)
                    report_mismatch("error", 64'(m_data.error), 64'(want.error));
            end
            results_seen++;
        end
    end

    // Receiver readiness: random stalls, a quiet stretch, and one long hold-off.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (results_seen > 300 && results_seen < 400) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(5, 60)) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (requests_sent == 500);
        hold_off = 1'b1;
        repeat (3000) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Directed table: expected value given only where it is obvious.
    typedef struct {
        req_t rq;
        bit   has_want;
        rsp_t want;
    } directed_row_t;

    function automatic directed_row_t row(mode_t m, logic [31:0] an, logic [30:0] ad,
                                          logic [31:0] bn, logic [30:0] bd,
                                          bit has_want = 0, logic [31:0] rn = 0,
                                          logic [30:0] rd = 1, logic eq = 0,
                                          err_t er = ERR_NONE);
        directed_row_t r;
        r.rq        = '{mode: m, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        r.has_want  = has_want;
        r.want      = '{res_num: rn, res_den: rd, is_equal: eq, error: er};
        return r;
    endfunction

    initial begin
        directed_row_t table_rows[$];
        req_t          rq;
        rsp_t          pred;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        mismatches      = 0;
        results_seen    = 0;
        requests_sent   = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        table_rows.push_back(row(MODE_ADD, 1, 2, 1, 3));
        table_rows.push_back(row(MODE_SUB, 1, 2, 1, 2, 1, 0, 1));
        table_rows.push_back(row(MODE_MUL, -3, 4, 2, 9));
        table_rows.push_back(row(MODE_DIV, 3, 4, -9, 8));
        table_rows.push_back(row(MODE_DIV, 5, 7, 0, 3, 1, 0, 1, 0, ERR_DIV_ZERO));
        table_rows.push_back(row(MODE_CMP, 2, 4, 1, 2, 1, 0, 1, 1));
        table_rows.push_back(row(MODE_CMP, 2, 4, -1, 2, 1, 0, 1, 0));
        table_rows.push_back(row(MODE_ADD, 1, 0, 1, 1, 1, 0, 1, 0, ERR_DIV_ZERO));
        table_rows.push_back(row(MODE_CMP, 1, 1, 1, 0, 1, 0, 1, 0, ERR_DIV_ZERO));
        table_rows.push_back(row(mode_t'(3'd5), 7, 1, 7, 1, 1, 0, 1));
        table_rows.push_back(row(mode_t'(3'd7), -1, 31'h7FFF_FFFF, -1, 0, 1, 0, 1));
        table_rows.push_back(row(MODE_MUL, 0, 5, 9, 7, 1, 0, 1));
        table_rows.push_back(row(MODE_ADD, 32'h7FFF_FFFF, 1, 1, 1, 1, 0, 1, 0,
            ERR_OVERFLOW));
        table_rows.push_back(row(MODE_SUB, 32'h8000_0000, 1, 1, 1, 1, 0, 1, 0,
            ERR_OVERFLOW));
        table_rows.push_back(row(MODE_MUL, 32'h8000_0000, 1, 1, 1, 1, 32'h8000_0000, 1));
        table_rows.push_back(row(MODE_MUL, 32'h8000_0000, 1, -1, 1, 1, 0, 1, 0,
            ERR_OVERFLOW));
        table_rows.push_back(row(MODE_DIV, 1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 0, 1, 0,
            ERR_OVERFLOW));
        table_rows.push_back(row(MODE_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000,
            31'h7FFF_FFFF));
        table_rows.push_back(row(MODE_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
            31'h7FFF_FFFE));
        table_rows.push_back(row(MODE_CMP, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000,
            31'h7FFF_FFFF, 1, 0, 1, 1));
        table_rows.push_back(row(MODE_DIV, 6, 1, 3, 1, 1, 2, 1));
        table_rows.push_back(row(MODE_DIV, 6, 1, -3, 1, 1, -2, 1));

        foreach (table_rows[i]) begin
            pred = reduce_fraction(table_rows[i].rq);
            if (table_rows[i].has_want && pred !== table_rows[i].want)
                $display("directed row %0d: typed result differs from prediction", i);
            send_request(table_rows[i].rq);
            if (table_rows[i].has_want) begin
                expected_results.pop_back();
                expected_results.push_back(table_rows[i].want);
            end
            sender_gap();
        end

        repeat (850) begin
            rq.mode  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
            rq.a_num = rand_num();
            rq.a_den = rand_den();
            rq.b_num = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_num();
            rq.b_den = rand_den();
            // Compare rows sometimes use scaled copies so equality shows up.
            if (rq.mode == MODE_CMP && $urandom_range(0, 1) == 1) begin
                rq.b_num = rq.a_num * 3;
                rq.b_den = 31'(rq.a_den * 3);
            end
            send_request(rq);
            sender_gap();
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d requests (directed table then random), checked %0d results,",
            requests_sent, results_seen);
        $display("including a long receiver hold-off that backed up the input.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
